[sv/lr_pkg.sv]
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types, codes and sizing for the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_BITS       = 12;
	localparam int ADDR_BITS      = 22;
	localparam int COLOR_BITS     = 32;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

	typedef enum logic [0:0] {
		KIND_LOAD    = 1'b0,
		KIND_ADVANCE = 1'b1
	} kind_t;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// width of one queued command: kind, four coords, two flags, three error terms, color
	function automatic int entry_bits(input int coord_bits);
		return 1 + 4 * coord_bits + 2 + 3 * (coord_bits + 3) + COLOR_BITS;
	endfunction

endpackage

[sv/lr_queue.sv]
// ----------------------------------------------------------------------------
// lr_queue
// Small register FIFO between the setup front end and the walker.
// ----------------------------------------------------------------------------
module lr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lr_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/lr_front.sv]
// ----------------------------------------------------------------------------
// lr_front
// Accepts requests, orders endpoints by x and derives the error-walk setup.
// ----------------------------------------------------------------------------
module lr_front #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          item_valid,
	output logic                                          item_ready,
	input  logic                                          kind,
	input  logic signed [COORD_BITS-1:0]                  start_x,
	input  logic signed [COORD_BITS-1:0]                  start_y,
	input  logic signed [COORD_BITS-1:0]                  end_x,
	input  logic signed [COORD_BITS-1:0]                  end_y,
	input  logic [lr_pkg::COLOR_BITS-1:0]                 pen_color,
	input  logic                                          q_full,
	output logic                                          q_push,
	output logic [lr_pkg::entry_bits(COORD_BITS)-1:0]     q_data
);

	localparam int C = COORD_BITS;
	localparam int E = COORD_BITS + 3;

	typedef struct packed {
		lr_pkg::kind_t               kind;
		logic [C-1:0]                ax;
		logic [C-1:0]                ay;
		logic [C-1:0]                bx;
		logic [C-1:0]                by;
		logic                        step_down;
		logic                        x_major;
		logic [E-1:0]                two_minor;
		logic [E-1:0]                two_mm;
		logic [E-1:0]                err;
		logic [lr_pkg::COLOR_BITS-1:0] color;
	} entry_t;

	logic                          swap;
	logic signed [C:0]             sx_e, sy_e, ex_e, ey_e, ay_e, by_e;
	logic                          down_in;
	logic [C:0]                    dx_in, dy_in;

	logic                          v_s1;
	lr_pkg::kind_t                 kind_s1;
	logic [C-1:0]                  ax_s1, ay_s1, bx_s1, by_s1;
	logic [C:0]                    dx_s1, dy_s1;
	logic                          down_s1;
	logic [lr_pkg::COLOR_BITS-1:0] color_s1;

	logic                          x_major;
	logic [C:0]                    major, minor;
	entry_t                        ent;

	always_comb begin
		sx_e    = $signed({start_x[C-1], start_x});
		sy_e    = $signed({start_y[C-1], start_y});
		ex_e    = $signed({end_x[C-1], end_x});
		ey_e    = $signed({end_y[C-1], end_y});
		swap    = start_x > end_x;
		ay_e    = swap ? ey_e : sy_e;
		by_e    = swap ? sy_e : ey_e;
		down_in = by_e < ay_e;
		dx_in   = swap ? (C + 1)'(sx_e - ex_e) : (C + 1)'(ex_e - sx_e);
		dy_in   = down_in ? (C + 1)'(ay_e - by_e) : (C + 1)'(by_e - ay_e);
	end

	assign item_ready = !v_s1 || !q_full;
	assign q_push     = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_ready) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			kind_s1  <= lr_pkg::kind_t'(kind);
			ax_s1    <= swap ? end_x : start_x;
			bx_s1    <= swap ? start_x : end_x;
			ay_s1    <= C'(ay_e);
			by_s1    <= C'(by_e);
			dx_s1    <= dx_in;
			dy_s1    <= dy_in;
			down_s1  <= down_in;
			color_s1 <= pen_color;
		end
	end

	always_comb begin
		x_major       = dx_s1 > dy_s1;
		major         = x_major ? dx_s1 : dy_s1;
		minor         = x_major ? dy_s1 : dx_s1;
		ent.kind      = kind_s1;
		ent.ax        = ax_s1;
		ent.ay        = ay_s1;
		ent.bx        = bx_s1;
		ent.by        = by_s1;
		ent.step_down = down_s1;
		ent.x_major   = x_major;
		ent.two_minor = E'({minor, 1'b0});
		ent.two_mm    = E'({minor, 1'b0}) - E'({major, 1'b0});
		ent.err       = E'({minor, 1'b0}) - E'(major);
		ent.color     = color_s1;
	end

	assign q_data = ent;

endmodule

[sv/lr_back.sv]
// ----------------------------------------------------------------------------
// lr_back
// Bresenham walker, clipping test and address pipeline with output register.
// ----------------------------------------------------------------------------
module lr_back #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic [lr_pkg::entry_bits(COORD_BITS)-1:0] q_data,
	input  logic                                      q_empty,
	output logic                                      q_pop,
	input  logic [lr_pkg::CFG_BITS-1:0]               image_width,
	input  logic [lr_pkg::CFG_BITS-1:0]               image_height,
	output logic                                      pixel_valid,
	input  logic                                      pixel_ready,
	output logic signed [COORD_BITS-1:0]              pixel_x,
	output logic signed [COORD_BITS-1:0]              pixel_y,
	output logic [lr_pkg::ADDR_BITS-1:0]              pixel_address,
	output logic [lr_pkg::COLOR_BITS-1:0]             pixel_color,
	output logic                                      inside_res,
	output logic                                      last_pixel
);

	localparam int C      = COORD_BITS;
	localparam int E      = COORD_BITS + 3;
	localparam int CMP_W  = (C > lr_pkg::CFG_BITS) ? C : lr_pkg::CFG_BITS;
	localparam int PROD_W = C + lr_pkg::CFG_BITS;
	localparam int SUM_W  = (PROD_W + 1 > lr_pkg::ADDR_BITS) ? PROD_W + 1 : lr_pkg::ADDR_BITS;

	typedef struct packed {
		lr_pkg::kind_t               kind;
		logic [C-1:0]                ax;
		logic [C-1:0]                ay;
		logic [C-1:0]                bx;
		logic [C-1:0]                by;
		logic                        step_down;
		logic                        x_major;
		logic [E-1:0]                two_minor;
		logic [E-1:0]                two_mm;
		logic [E-1:0]                err;
		logic [lr_pkg::COLOR_BITS-1:0] color;
	} entry_t;

	entry_t                        ent;
	logic                          adv;
	logic                          do_load;
	logic                          do_step;

	logic                          line_active_q, first_pending_q, x_major_q, step_down_q;
	logic [C-1:0]                  cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic [E-1:0]                  err_q, two_minor_q, two_mm_q;
	logic [lr_pkg::COLOR_BITS-1:0] color_q;

	logic [C-1:0]                  nx, ny, y_step;
	logic [E-1:0]                  nerr;
	logic                          nlast;

	logic                          v_s1, last_s1;
	logic [C-1:0]                  x_s1, y_s1;
	logic [lr_pkg::COLOR_BITS-1:0] color_s1;
	logic                          inside_in;

	logic                          v_s2, last_s2, inside_s2;
	logic [C-1:0]                  x_s2, y_s2;
	logic [lr_pkg::COLOR_BITS-1:0] color_s2;
	logic [PROD_W-1:0]             prod_s2;
	logic [SUM_W-1:0]              sum;

	logic                          out_valid_q, last_q, inside_q;
	logic [C-1:0]                  px_q, py_q;
	logic [lr_pkg::ADDR_BITS-1:0]  addr_q;
	logic [lr_pkg::COLOR_BITS-1:0] pcolor_q;

	assign ent     = q_data;
	assign adv     = !out_valid_q || pixel_ready;
	assign q_pop   = adv && !q_empty;
	assign do_load = q_pop && (ent.kind == lr_pkg::KIND_LOAD);
	assign do_step = q_pop && (ent.kind == lr_pkg::KIND_ADVANCE) && line_active_q;

	always_comb begin
		y_step = step_down_q ? cur_y_q - C'(1) : cur_y_q + C'(1);
		nx     = cur_x_q;
		ny     = cur_y_q;
		nerr   = err_q;
		if (!first_pending_q) begin
			if (x_major_q) begin
				nx = cur_x_q + C'(1);
				if (err_q[E-1]) begin
					nerr = err_q + two_minor_q;
				end else begin
					ny   = y_step;
					nerr = err_q + two_mm_q;
				end
			end else begin
				ny = y_step;
				if (err_q[E-1]) begin
					nerr = err_q + two_minor_q;
				end else begin
					nx   = cur_x_q + C'(1);
					nerr = err_q + two_mm_q;
				end
			end
		end
		nlast = x_major_q ? ($signed(nx) >= $signed(stop_x_q)) : (ny == stop_y_q);
	end

	// walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q   <= 1'b0;
			first_pending_q <= 1'b0;
		end else if (do_load) begin
			line_active_q   <= 1'b1;
			first_pending_q <= 1'b1;
		end else if (do_step) begin
			line_active_q   <= !nlast;
			first_pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			x_major_q   <= ent.x_major;
			step_down_q <= ent.step_down;
			cur_x_q     <= ent.ax;
			cur_y_q     <= ent.ay;
			stop_x_q    <= ent.bx;
			stop_y_q    <= ent.by;
			err_q       <= ent.err;
			two_minor_q <= ent.two_minor;
			two_mm_q    <= ent.two_mm;
			color_q     <= ent.color;
		end else if (do_step) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			err_q   <= nerr;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= do_step;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign inside_in = !x_s1[C-1] && !y_s1[C-1] &&
	                   (CMP_W'(x_s1) < CMP_W'(image_width)) &&
	                   (CMP_W'(y_s1) < CMP_W'(image_height));

	assign sum = SUM_W'(prod_s2) + SUM_W'(x_s2);

	always_ff @(posedge clk) begin
		if (do_step) begin
			x_s1     <= nx;
			y_s1     <= ny;
			last_s1  <= nlast;
			color_s1 <= color_q;
		end
		if (adv && v_s1) begin
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			last_s2   <= last_s1;
			color_s2  <= color_s1;
			inside_s2 <= inside_in;
			prod_s2   <= PROD_W'(y_s1) * PROD_W'(image_width);
		end
		if (adv && v_s2) begin
			px_q     <= x_s2;
			py_q     <= y_s2;
			last_q   <= last_s2;
			pcolor_q <= color_s2;
			inside_q <= inside_s2;
			addr_q   <= inside_s2 ? sum[lr_pkg::ADDR_BITS-1:0] : '0;
		end
	end

	assign pixel_valid   = out_valid_q;
	assign pixel_x       = $signed(px_q);
	assign pixel_y       = $signed(py_q);
	assign pixel_address = addr_q;
	assign pixel_color   = pcolor_q;
	assign inside_res    = inside_q;
	assign last_pixel    = last_q;

	a_first_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		first_pending_q |-> line_active_q)
		else $error("first pixel pending without an active line");

	a_x_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(line_active_q && x_major_q) |-> ($signed(cur_x_q) <= $signed(stop_x_q)))
		else $error("x-major walk ran past its end point");

	a_clipped_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !inside_q) |-> (addr_q == '0))
		else $error("clipped pixel carries a nonzero address");

endmodule

[sv/line_rasterizer.sv]
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line rasterizer: load a line, then emit one pixel per advance.
// ----------------------------------------------------------------------------
// An advance request passes through the front setup register, the queue, the walker stage,
// the multiply stage and the output register before its pixel appears.
// Throughput: one request per cycle unless the output stalls; the walker updates its error term once a cycle.
// A 4-entry queue lets requests keep coming while a pixel waits on the output.
// Reset (arst_n low): no line active, queue empty, width 640, height 480.
module line_rasterizer #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic                                  kind,
	input  logic signed [COORD_BITS-1:0]          start_x,
	input  logic signed [COORD_BITS-1:0]          start_y,
	input  logic signed [COORD_BITS-1:0]          end_x,
	input  logic signed [COORD_BITS-1:0]          end_y,
	input  logic [lr_pkg::COLOR_BITS-1:0]         pen_color,
	output logic                                  pixel_valid,
	input  logic                                  pixel_ready,
	output logic signed [COORD_BITS-1:0]          pixel_x,
	output logic signed [COORD_BITS-1:0]          pixel_y,
	output logic [lr_pkg::ADDR_BITS-1:0]          pixel_address,
	output logic [lr_pkg::COLOR_BITS-1:0]         pixel_color,
	output logic                                  inside_res,
	output logic                                  last_pixel
);

	localparam int ENTRY_W = lr_pkg::entry_bits(COORD_BITS);

	logic [lr_pkg::CFG_BITS-1:0] width_q, height_q;
	lr_pkg::reg_idx_t            reg_idx;
	logic                        cfg_wr;

	logic               q_push, q_pop, q_full, q_empty;
	logic [ENTRY_W-1:0] q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = lr_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lr_pkg::WIDTH_RESET;
			height_q <= lr_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				lr_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[lr_pkg::CFG_BITS-1:0];
				lr_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[lr_pkg::CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			lr_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			lr_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			default:                  prdata = '0;
		endcase
	end

	lr_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.kind       (kind),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.pen_color  (pen_color),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	lr_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (lr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wdata),
		.pop     (q_pop),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	lr_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_data        (q_rdata),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.image_width   (width_q),
		.image_height  (height_q),
		.pixel_valid   (pixel_valid),
		.pixel_ready   (pixel_ready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.inside_res    (inside_res),
		.last_pixel    (last_pixel)
	);

endmodule
